FILE: rtl/keyframe_track_sampler_macros.svh
// Assertion macros for the keyframe track sampler.
// Included by the top level; no other dependencies.
`ifndef KEYFRAME_TRACK_SAMPLER_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define KTS_ASSERT(label, clk, rst_n, prop, msg)
`define KTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/kts_pkg.sv
// Shared types and constants of the keyframe track sampler.
// No dependencies.
`timescale 1ns / 1ps
package kts_pkg;
	localparam int MAX_KEYS   = 64;
	localparam int IDX_W      = $clog2(MAX_KEYS);
	localparam int CNT_W      = $clog2(MAX_KEYS + 1);
	localparam int TIME_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int FRAC_W     = FRAC_BITS + 1;
	localparam int FSTEP_W    = $clog2(FRAC_BITS);
	localparam int MSTEP_W    = $clog2(TIME_W);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_ROTATE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [TIME_W-1:0]  tv;
		logic [IDX_W-1:0]   idx;
		logic [CNT_W-1:0]   count;
	} chain_ctl_t;
endpackage

FILE: rtl/kts_cell.sv
// One key cell: holds one key time and trades it with its neighbors.
// Depends on kts_pkg.
`timescale 1ns / 1ps
module kts_cell (
	input  logic                         clk,
	input  kts_pkg::cmd_t                cmd,
	input  logic [kts_pkg::TIME_W-1:0]   tv,
	input  logic                         in_use,
	input  logic                         at_or_past_idx,
	input  logic [kts_pkg::TIME_W-1:0]   left_key,
	input  logic                         left_keep,
	input  logic [kts_pkg::TIME_W-1:0]   right_key,
	output logic [kts_pkg::TIME_W-1:0]   key,
	output logic                         keep
);
	logic [kts_pkg::TIME_W-1:0] key_q;

	assign key  = key_q;
	// stays in place on insert: a used key strictly below the new time
	assign keep = in_use && (key_q < tv);

	always_ff @(posedge clk) begin
		case (cmd)
			kts_pkg::CMD_INSERT: begin
				if (!keep) begin
					key_q <= left_keep ? tv : left_key;
				end
			end
			kts_pkg::CMD_REMOVE: begin
				if (at_or_past_idx) begin
					key_q <= right_key;
				end
			end
			kts_pkg::CMD_ROTATE: key_q <= right_key;
			default: key_q <= key_q;
		endcase
	end
endmodule

FILE: rtl/kts_chain.sv
// Row of key cells; cell 0 is the head seen by the sequencer.
// Depends on kts_pkg and kts_cell.
`timescale 1ns / 1ps
module kts_chain (
	input  logic                        clk,
	input  kts_pkg::chain_ctl_t         ctl,
	output logic [kts_pkg::TIME_W-1:0]  head
);
	logic [kts_pkg::TIME_W-1:0] keys  [kts_pkg::MAX_KEYS];
	logic                       keeps [kts_pkg::MAX_KEYS];

	assign head = keys[0];

	for (genvar i = 0; i < kts_pkg::MAX_KEYS; i++) begin : g_cell
		logic [kts_pkg::TIME_W-1:0] lk;
		logic                       lkeep;
		logic [kts_pkg::TIME_W-1:0] rk;
		if (i == 0) begin : g_first
			assign lk    = keys[0];
			assign lkeep = 1'b1;
		end else begin : g_mid
			assign lk    = keys[i-1];
			assign lkeep = keeps[i-1];
		end
		// last cell wraps to the head so a rotation restores order
		if (i == kts_pkg::MAX_KEYS - 1) begin : g_last
			assign rk = keys[0];
		end else begin : g_inner
			assign rk = keys[i+1];
		end
		kts_cell u_cell (
			.clk            (clk),
			.cmd            (ctl.cmd),
			.tv             (ctl.tv),
			.in_use         (kts_pkg::CNT_W'(i) < ctl.count),
			.at_or_past_idx (kts_pkg::IDX_W'(i) >= ctl.idx),
			.left_key       (lk),
			.left_keep      (lkeep),
			.right_key      (rk),
			.key            (keys[i]),
			.keep           (keeps[i])
		);
	end
endmodule

FILE: rtl/keyframe_track_sampler.sv
// Insert, remove and clear go from accept straight to the done state.
// A query steps through a bitwise modulo (only if the time wraps),
// a full rotation of the key chain, a prep step and, if the fraction is
// not trivial, a bitwise restoring divide. One item at a time.
// arst_n clears count, length and handshake state; key cells are not reset.
`timescale 1ns / 1ps
`include "keyframe_track_sampler_macros.svh"
module keyframe_track_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,      // animation_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,       // operation[1:0], time_value[33:2], key_index[39:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata        // status, first_index, second_index, fraction, key_count, pad
);
	localparam int TW = kts_pkg::TIME_W;
	localparam int IW = kts_pkg::IDX_W;
	localparam int CW = kts_pkg::CNT_W;
	localparam int FB = kts_pkg::FRAC_BITS;
	localparam int FW = kts_pkg::FRAC_W;

	typedef enum logic [2:0] {S_IDLE, S_MOD, S_SCAN, S_PREP, S_DIV, S_DONE} state_t;

	state_t                  state_q;
	logic [TW-1:0]           len_q;
	logic [CW-1:0]           count_q;
	kts_pkg::op_t            op_q;
	logic [TW-1:0]           t_q;
	logic [IW-1:0]           idx_q;
	logic [TW:0]             mrem_q;
	logic [kts_pkg::MSTEP_W-1:0] mstep_q;
	logic [IW-1:0]           j_q;
	logic                    found_q;
	logic [TW-1:0]           prev_q, k0_q, last_q, t1_q, t2_q;
	logic [IW-1:0]           first_q, second_q;
	logic [TW+1:0]           drem_q;
	logic [TW:0]             den_q;
	logic [FB-1:0]           quo_q;
	logic [kts_pkg::FSTEP_W-1:0] dstep_q;
	logic [FW-1:0]           frac_q;
	logic [39:0]             out_q;
	logic                    out_valid_q;

	kts_pkg::chain_ctl_t     ctl;
	logic [TW-1:0]           head;
	logic                    out_free;
	logic [TW:0]             mshift;
	logic [TW-1:0]           t_dec;
	logic [TW+1:0]           dshift;
	logic [TW:0]             t2f;
	logic [TW-1:0]           t1f;
	kts_pkg::status_t        status;
	logic [CW-1:0]           count_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign out_free  = !out_valid_q || m_tready;
	assign t_dec     = t_q - TW'(1);
	assign mshift    = {mrem_q[TW-1:0], t_dec[mstep_q]};
	assign dshift    = {drem_q[TW:0], 1'b0};
	assign t2f       = found_q ? {1'b0, t2_q} : ({1'b0, len_q} + {1'b0, k0_q});
	assign t1f       = found_q ? t1_q : last_q;

	always_comb begin
		status     = kts_pkg::ST_OK;
		count_next = count_q;
		unique case (op_q)
			kts_pkg::OP_INSERT: begin
				if (count_q == CW'(kts_pkg::MAX_KEYS)) status = kts_pkg::ST_FULL;
				else count_next = count_q + CW'(1);
			end
			kts_pkg::OP_REMOVE: begin
				if ({1'b0, idx_q} >= count_q) status = kts_pkg::ST_RANGE;
				else count_next = count_q - CW'(1);
			end
			kts_pkg::OP_CLEAR: count_next = '0;
			kts_pkg::OP_QUERY: begin
				if (count_q == '0) status = kts_pkg::ST_EMPTY;
			end
			default: status = kts_pkg::ST_OK;
		endcase
	end

	always_comb begin
		ctl.cmd   = kts_pkg::CMD_HOLD;
		ctl.tv    = t_q;
		ctl.idx   = idx_q;
		ctl.count = count_q;
		if (state_q == S_SCAN) begin
			ctl.cmd = kts_pkg::CMD_ROTATE;
		end else if (state_q == S_DONE && out_free && status == kts_pkg::ST_OK) begin
			if (op_q == kts_pkg::OP_INSERT) ctl.cmd = kts_pkg::CMD_INSERT;
			else if (op_q == kts_pkg::OP_REMOVE) ctl.cmd = kts_pkg::CMD_REMOVE;
		end
	end

	kts_chain u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.head (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q     <= kts_pkg::op_t'(s_tdata[1:0]);
						t_q      <= s_tdata[33:2];
						idx_q    <= s_tdata[39:34];
						mrem_q   <= '0;
						mstep_q  <= kts_pkg::MSTEP_W'(TW - 1);
						j_q      <= '0;
						found_q  <= 1'b0;
						frac_q   <= '0;
						first_q  <= '0;
						second_q <= '0;
						if (kts_pkg::op_t'(s_tdata[1:0]) != kts_pkg::OP_QUERY || count_q == '0)
							state_q <= S_DONE;
						else if (len_q != '0 && s_tdata[33:2] > len_q)
							state_q <= S_MOD;
						else
							state_q <= S_SCAN;
					end
				end
				S_MOD: begin
					// restoring modulo of (t - 1) by the length, one bit a cycle
					mrem_q  <= (mshift >= {1'b0, len_q}) ? mshift - {1'b0, len_q} : mshift;
					mstep_q <= mstep_q - kts_pkg::MSTEP_W'(1);
					if (mstep_q == '0) begin
						t_q     <= ((mshift >= {1'b0, len_q}) ? mshift[TW-1:0] - len_q
						           : mshift[TW-1:0]) + TW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// head shows key j; the chain rotates one place per cycle
					prev_q <= head;
					if (j_q == '0) k0_q <= head;
					if ({1'b0, j_q} == count_q - CW'(1)) last_q <= head;
					if ({1'b0, j_q} < count_q && !found_q && head >= t_q) begin
						found_q  <= 1'b1;
						second_q <= j_q;
						t2_q     <= head;
						if (j_q != '0 && t_q < head) begin
							first_q <= j_q - IW'(1);
							t1_q    <= prev_q;
						end else begin
							first_q <= j_q;
							t1_q    <= head;
						end
					end
					j_q <= j_q + IW'(1);
					if (j_q == IW'(kts_pkg::MAX_KEYS - 1)) state_q <= S_PREP;
				end
				S_PREP: begin
					if (!found_q) begin
						first_q  <= IW'(count_q - CW'(1));
						second_q <= '0;
					end
					den_q   <= t2f - {1'b0, t1f};
					drem_q  <= {2'b0, t_q - t1f};
					quo_q   <= '0;
					dstep_q <= kts_pkg::FSTEP_W'(FB - 1);
					if (t2f > {1'b0, t1f} && t_q > t1f) begin
						if ({1'b0, t_q - t1f} >= t2f - {1'b0, t1f}) begin
							frac_q  <= FW'(1) << FB;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (dshift >= {1'b0, den_q}) begin
						drem_q <= dshift - {1'b0, den_q};
						quo_q  <= {quo_q[FB-2:0], 1'b1};
					end else begin
						drem_q <= dshift;
						quo_q  <= {quo_q[FB-2:0], 1'b0};
					end
					dstep_q <= dstep_q - kts_pkg::FSTEP_W'(1);
					if (dstep_q == '0) begin
						frac_q  <= {1'b0, quo_q[FB-2:0], (dshift >= {1'b0, den_q})};
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						count_q     <= count_next;
						if (op_q == kts_pkg::OP_QUERY && status == kts_pkg::ST_OK)
							out_q <= {2'b0, count_next, frac_q, second_q, first_q, status};
						else
							out_q <= {2'b0, count_next, FW'(0), IW'(0), IW'(0), status};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`KTS_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(kts_pkg::MAX_KEYS), "key count overflow")
	`KTS_ASSERT(a_empty_zero, clk, arst_n, !(m_tvalid && m_tdata[1:0] == kts_pkg::ST_EMPTY) || m_tdata[37:31] == '0, "empty status with keys")
	`KTS_ASSERT_NEXT(a_accept_busy, clk, arst_n, s_tvalid && s_tready, !s_tready, "accepted item while busy")
	`KTS_ASSERT(a_frac_bound, clk, arst_n, !m_tvalid || m_tdata[30:14] <= (FW'(1) << FB), "fraction above one")
endmodule
